### src/psgtn_pkg.sv
// ---------------------------------------------------------------------------
// psgtn_pkg
// Shared types, register map and codes for the tone/noise/envelope generator.
// ---------------------------------------------------------------------------
package psgtn_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] dac_index;
  } out_item_t;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // register map
  localparam logic [3:0] REG_NOISE      = 4'd6;
  localparam logic [3:0] REG_MIXER      = 4'd7;
  localparam logic [3:0] REG_VOL0       = 4'd8;
  localparam logic [3:0] REG_ENV_FINE   = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE = 4'd12;
  localparam logic [3:0] REG_SHAPE      = 4'd13;

  localparam int MAX_CHANNELS = 3;
  localparam int DIV_STEPS    = 13;
  localparam int DIV_CNT_W    = 4;

  // datapath commands from the controller
  typedef struct packed {
    logic latch;
    logic reg_wr;
    logic tone_eval;
    logic div_start;
    logic div_step;
    logic div_end;
    logic ne_step;
    logic out_load;
  } dp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic is_write;
    logic is_tick;
    logic need_div;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] read_mask(input logic [3:0] addr);
    logic [7:0] m;
    unique case (addr) inside
      4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0F;
      4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1F;
      default:                 m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

### src/psgtn_ctrl.sv
// ---------------------------------------------------------------------------
// psgtn_ctrl
// Sequencer: walks one item through decode, per-channel tone update,
// noise/envelope update (both for ticks only) and result hand-off.
// ---------------------------------------------------------------------------
module psgtn_ctrl #(
  parameter int NUM_CHANNELS = psgtn_pkg::MAX_CHANNELS,
  parameter int CH_W         = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  psgtn_pkg::dp_status_t  status,
  output psgtn_pkg::dp_cmd_t     cmd,
  output logic [CH_W-1:0]        ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_TONE, S_DIV, S_DIVEND, S_NE, S_DONE
  } state_t;

  state_t                               state_r, state_nxt;
  logic [CH_W-1:0]                      ch_r, ch_nxt;
  logic [psgtn_pkg::DIV_CNT_W-1:0]      step_r, step_nxt;
  logic                                 last_ch;

  assign last_ch  = (ch_r == CH_W'(NUM_CHANNELS - 1));
  assign in_stall = (state_r != S_IDLE);
  assign ch       = ch_r;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.reg_wr = status.is_write;
        ch_nxt     = '0;
        state_nxt  = status.is_tick ? S_TONE : S_DONE;
      end
      S_TONE: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          step_nxt      = '0;
          state_nxt     = S_DIV;
        end else begin
          cmd.tone_eval = 1'b1;
          ch_nxt        = ch_r + CH_W'(1);
          state_nxt     = last_ch ? S_NE : S_TONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + psgtn_pkg::DIV_CNT_W'(1);
        if (step_r == psgtn_pkg::DIV_CNT_W'(psgtn_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_DIVEND;
        end
      end
      S_DIVEND: begin
        cmd.div_end = 1'b1;
        ch_nxt      = ch_r + CH_W'(1);
        state_nxt   = last_ch ? S_NE : S_TONE;
      end
      S_NE: begin
        cmd.ne_step = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      step_r  <= step_nxt;
    end
  end

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (step_r < psgtn_pkg::DIV_CNT_W'(psgtn_pkg::DIV_STEPS)))
    else $error("divider step count overran");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted item did not start processing");

  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status.out_free) |=> !in_stall)
    else $error("result hand-off did not return to idle");

endmodule

### src/psgtn_dp.sv
// ---------------------------------------------------------------------------
// psgtn_dp
// Datapath: register file, tone dividers with a shared restoring divider,
// noise LFSR, envelope generator, mixer and result register.
// ---------------------------------------------------------------------------
module psgtn_dp #(
  parameter int NUM_CHANNELS = psgtn_pkg::MAX_CHANNELS,
  parameter int CH_W         = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  psgtn_pkg::in_item_t    in_item,
  input  psgtn_pkg::dp_cmd_t     cmd,
  input  logic [CH_W-1:0]        ch,
  output psgtn_pkg::dp_status_t  status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output psgtn_pkg::out_item_t   out_item
);

  psgtn_pkg::in_item_t  item_r;
  psgtn_pkg::out_item_t out_item_r, res;
  logic                 out_valid_r;

  logic [7:0]  reg_file_r [16];
  logic [11:0] tone_count_r [NUM_CHANNELS];
  logic [4:0]  tone_phase_r [NUM_CHANNELS];
  logic        tone_level_r [NUM_CHANNELS];
  logic [4:0]  noise_count_r;
  logic        noise_pre_r;
  logic [16:0] lfsr_r;
  logic [16:0] env_count_r;
  logic [4:0]  env_step_r;
  logic        env_att_r, env_hold_r, env_alt_r, env_holding_r;
  logic [11:0] div_rem_r;
  logic [12:0] div_dvd_r;
  logic [4:0]  div_q_r;

  logic [3:0]  addr4, lo_idx, hi_idx;
  logic        addr_hi;
  logic [11:0] per_raw, per;
  logic [12:0] cnt, per13, fast_cnt, trial, diff;
  logic        ge1, trial_ge;
  logic [4:0]  ph_dec, ph_div;
  logic [5:0]  nc1;
  logic [17:0] ec1;
  logic [16:0] eper2;
  logic [4:0]  es_dec;
  logic [3:0]  env_vol;

  assign addr4   = item_r.reg_addr[3:0];
  assign addr_hi = |item_r.reg_addr[7:4];
  assign lo_idx  = 4'({ch, 1'b0});
  assign hi_idx  = 4'({ch, 1'b1});
  assign per_raw = {reg_file_r[hi_idx][3:0], reg_file_r[lo_idx]};
  assign per     = (per_raw == 12'd0) ? 12'd1 : per_raw;
  assign per13   = {1'b0, per};
  assign cnt     = {1'b0, tone_count_r[ch]} + 13'd1;
  assign ge1     = (cnt >= per13);
  assign fast_cnt = ge1 ? (cnt - per13) : cnt;
  assign ph_dec  = tone_phase_r[ch] - 5'd1;
  assign ph_div  = tone_phase_r[ch] - div_q_r;
  assign trial   = {div_rem_r, div_dvd_r[12]};
  assign trial_ge = (trial >= per13);
  assign diff    = trial - per13;

  assign nc1     = {1'b0, noise_count_r} + 6'd1;
  assign ec1     = {1'b0, env_count_r} + 18'd1;
  assign eper2   = {reg_file_r[psgtn_pkg::REG_ENV_COARSE],
                    reg_file_r[psgtn_pkg::REG_ENV_FINE], 1'b0};
  assign es_dec  = env_step_r - 5'd1;
  assign env_vol = env_step_r[3:0] ^ {4{env_att_r}};

  assign status.is_write = (item_r.command == psgtn_pkg::CMD_WRITE);
  assign status.is_tick  = (item_r.command == psgtn_pkg::CMD_TICK);
  assign status.need_div = (cnt >= {per, 1'b0});
  assign status.out_free = !out_valid_r || !out_stall;

  // result for the latched item
  always_comb begin
    logic [7:0] vreg;
    logic       on;
    res = '0;
    vreg = '0;
    on = 1'b0;
    if (item_r.command == psgtn_pkg::CMD_READ) begin
      res.read_data = addr_hi ? 8'hFF : (reg_file_r[addr4] & psgtn_pkg::read_mask(addr4));
    end else if (item_r.command == psgtn_pkg::CMD_TICK) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        vreg = reg_file_r[psgtn_pkg::REG_VOL0 + 4'(c)];
        on = (tone_level_r[c] | reg_file_r[psgtn_pkg::REG_MIXER][c]) &
             (lfsr_r[0] | reg_file_r[psgtn_pkg::REG_MIXER][3 + c]);
        if (vreg[4]) begin
          res.dac_index[12 + c] = 1'b1;
          if (on) res.dac_index[4*c +: 4] = env_vol;
        end else if (on) begin
          res.dac_index[4*c +: 4] = vreg[3:0];
        end
      end
    end
  end

  // generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) reg_file_r[i] <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        tone_count_r[c] <= '0;
        tone_phase_r[c] <= '0;
        tone_level_r[c] <= 1'b0;
      end
      noise_count_r <= '0;
      noise_pre_r   <= 1'b0;
      lfsr_r        <= 17'd1;
      env_count_r   <= '0;
      env_step_r    <= 5'd15;
      env_att_r     <= 1'b0;
      env_hold_r    <= 1'b1;
      env_alt_r     <= 1'b0;
      env_holding_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.reg_wr && !addr_hi) begin
        reg_file_r[addr4] <= item_r.write_data;
        if (addr4 == psgtn_pkg::REG_SHAPE) begin
          env_att_r <= item_r.write_data[2];
          if (!item_r.write_data[3]) begin
            env_hold_r <= 1'b1;
            env_alt_r  <= item_r.write_data[2];
          end else begin
            env_hold_r <= item_r.write_data[0];
            env_alt_r  <= item_r.write_data[1];
          end
          env_step_r    <= 5'd15;
          env_holding_r <= 1'b0;
        end
      end
      if (cmd.tone_eval) begin
        tone_count_r[ch] <= fast_cnt[11:0];
        if (ge1) begin
          tone_phase_r[ch] <= ph_dec;
          tone_level_r[ch] <= ph_dec[0];
        end
      end
      if (cmd.div_end) begin
        tone_count_r[ch] <= div_rem_r;
        tone_phase_r[ch] <= ph_div;
        tone_level_r[ch] <= ph_div[0];
      end
      if (cmd.ne_step) begin
        if (nc1 >= {1'b0, reg_file_r[psgtn_pkg::REG_NOISE][4:0]}) begin
          noise_count_r <= '0;
          noise_pre_r   <= !noise_pre_r;
          if (noise_pre_r) begin
            lfsr_r <= {lfsr_r[0] ^ lfsr_r[3], lfsr_r[16:1]};
          end
        end else begin
          noise_count_r <= nc1[4:0];
        end
        if (!env_holding_r) begin
          if (ec1 >= {1'b0, eper2}) begin
            env_count_r <= '0;
            if (es_dec[4]) begin
              if (env_alt_r) env_att_r <= !env_att_r;
              if (env_hold_r) begin
                env_holding_r <= 1'b1;
                env_step_r    <= '0;
              end else begin
                env_step_r <= {1'b0, es_dec[3:0]};
              end
            end else begin
              env_step_r <= es_dec;
            end
          end else begin
            env_count_r <= ec1[16:0];
          end
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: item latch, divider, result
  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_item;
    if (cmd.div_start) begin
      div_rem_r <= '0;
      div_dvd_r <= cnt;
      div_q_r   <= '0;
    end else if (cmd.div_step) begin
      div_rem_r <= trial_ge ? diff[11:0] : trial[11:0];
      div_dvd_r <= {div_dvd_r[11:0], 1'b0};
      div_q_r   <= {div_q_r[3:0], trial_ge};
    end
    if (cmd.out_load) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while waiting");

  a_hold_step: assert property (@(posedge clk) disable iff (!rst_n)
    env_holding_r |-> (env_step_r == 5'd0))
    else $error("envelope holding with nonzero step");

  a_level_phase: assert property (@(posedge clk) disable iff (!rst_n)
    tone_level_r[0] == tone_phase_r[0][0])
    else $error("tone level out of step with phase");

endmodule

### src/psg_tone_noise_envelope.sv
// ---------------------------------------------------------------------------
// psg_tone_noise_envelope
// Three-channel tone/noise/envelope sound generator with a 16-register file.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carry one item: a register write, a register
//   read or one generator tick. out_valid/out_stall/out_item return exactly
//   one result per item: read_data on a read, dac_index on a tick, zero
//   fields otherwise. dac_index holds three 4-bit levels and envelope-select
//   bits 12-14; the external resistor table maps it to an analog level.
// Sequence:
//   A write or read is decoded and then loaded into the result register; a
//   tick first updates each tone channel in turn and then the noise and
//   envelope generators. A tone counter that advances by at most one period
//   is updated directly; a channel whose period was lowered far below its
//   count runs the shared restoring divider for that channel.
//   The next item is accepted once the result is loaded, so an unread
//   result does not block the next item until its own result is ready.
// Reset (rst_n low, synchronous): registers clear, envelope restarts as if
//   shape 0 were written, noise LFSR loads 1, output goes invalid.
// Stall: a result waits in the output register while out_stall is high.
// ---------------------------------------------------------------------------
module psg_tone_noise_envelope #(
  parameter int NUM_CHANNELS = psgtn_pkg::MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  psgtn_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output psgtn_pkg::out_item_t  out_item
);

  // channel index width; one bit even for a single channel
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  psgtn_pkg::dp_cmd_t    cmd;
  psgtn_pkg::dp_status_t status;
  logic [CH_W-1:0]       ch;

  psgtn_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .CH_W         (CH_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .ch       (ch)
  );

  psgtn_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .CH_W         (CH_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .ch        (ch),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### tb/tb_psg_tone_noise_envelope.sv
// ---------------------------------------------------------------------------
// tb_psg_tone_noise_envelope
// Self-checking bench for the tone/noise/envelope generator: directed and
// random register writes, reads and ticks, checked against a cycle-free model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_psg_tone_noise_envelope;

  localparam int CYCLE_LIMIT = 1500000;

  // command code with no operation
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // tone period registers
  localparam int REG_TONE_A_FINE   = 0;
  localparam int REG_TONE_A_COARSE = 1;
  localparam int REG_TONE_B_FINE   = 2;
  localparam int REG_TONE_B_COARSE = 3;
  localparam int REG_TONE_C_COARSE = 5;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  psgtn_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_stall;
  psgtn_pkg::out_item_t out_item;

  psg_tone_noise_envelope dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Predicted generator state, mirroring the block's registers.
  logic [7:0]  regs [16];
  logic [11:0] tcnt [3];
  logic [4:0]  tphase [3];
  logic        tlevel [3];
  logic [5:0]  ncnt;
  logic        npre;
  logic [16:0] lfsr;
  logic [16:0] ecnt;
  logic [4:0]  estep;
  logic [3:0]  eattack;
  logic        ehold, ealt, eholding;

  psgtn_pkg::out_item_t expected_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  hold_off = 0;

  function automatic logic [7:0] mask_of(input int a);
    case (a)
      1, 3, 5, 13: return 8'h0F;
      6, 8, 9, 10: return 8'h1F;
      default:     return 8'hFF;
    endcase
  endfunction

  function automatic void shape_load(input logic [7:0] s);
    eattack = s[2] ? 4'hF : 4'h0;
    if (!s[3]) begin
      ehold = 1'b1;
      ealt  = s[2];
    end else begin
      ehold = s[0];
      ealt  = s[1];
    end
    estep    = 5'd15;
    eholding = 1'b0;
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < 16; i++) regs[i] = '0;
    for (int c = 0; c < 3; c++) begin
      tcnt[c] = '0; tphase[c] = '0; tlevel[c] = 1'b0;
    end
    ncnt = '0; npre = 1'b0; lfsr = 17'd1; ecnt = '0;
    shape_load(8'h00);
  endfunction

  function automatic logic [14:0] tick_index();
    int unsigned per, cnt, eper;
    logic [3:0]  evol, vol;
    logic        on;
    logic [14:0] idx;
    idx = '0;
    for (int c = 0; c < 3; c++) begin
      per = {regs[2*c+1][3:0], regs[2*c]};
      cnt = tcnt[c] + 1;
      if (per < 1) per = 1;
      while (cnt >= per) begin
        tphase[c] = tphase[c] - 5'd1;
        tlevel[c] = tphase[c][0];
        cnt -= per;
      end
      tcnt[c] = cnt[11:0];
    end
    ncnt = ncnt + 6'd1;
    if (ncnt >= regs[psgtn_pkg::REG_NOISE][4:0]) begin
      ncnt = '0;
      npre = ~npre;
      if (!npre) lfsr = {lfsr[0] ^ lfsr[3], lfsr[16:1]};
    end
    if (!eholding) begin
      eper = {regs[psgtn_pkg::REG_ENV_COARSE], regs[psgtn_pkg::REG_ENV_FINE]};
      ecnt = ecnt + 17'd1;
      if (ecnt >= eper * 2) begin
        ecnt  = '0;
        estep = estep - 5'd1;
        if (estep[4]) begin
          if (ealt) eattack = ~eattack;
          if (ehold) begin
            eholding = 1'b1;
            estep    = '0;
          end else begin
            estep[4] = 1'b0;
          end
        end
      end
    end
    evol = estep[3:0] ^ eattack;
    for (int c = 0; c < 3; c++) begin
      on = (tlevel[c] | regs[psgtn_pkg::REG_MIXER][c]) &
           (lfsr[0] | regs[psgtn_pkg::REG_MIXER][3+c]);
      if (regs[psgtn_pkg::REG_VOL0 + c][4]) begin
        idx[12+c] = 1'b1;
        vol = evol;
      end else begin
        vol = regs[psgtn_pkg::REG_VOL0 + c][3:0];
      end
      if (on) idx[4*c +: 4] = vol;
    end
    return idx;
  endfunction

  function automatic psgtn_pkg::out_item_t predict(input psgtn_pkg::in_item_t it);
    psgtn_pkg::out_item_t r;
    r = '0;
    case (it.command)
      psgtn_pkg::CMD_WRITE: if (it.reg_addr < 16) begin
        regs[it.reg_addr[3:0]] = it.write_data;
        if (it.reg_addr == psgtn_pkg::REG_SHAPE) shape_load(it.write_data);
      end
      psgtn_pkg::CMD_READ:  r.read_data = (it.reg_addr < 16) ?
                   (regs[it.reg_addr[3:0]] & mask_of(it.reg_addr)) : 8'hFF;
      psgtn_pkg::CMD_TICK:  r.dac_index = tick_index();
      default: ;
    endcase
    return r;
  endfunction

  // Send one item; hold it until the block accepts it.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] a, input logic [7:0] d);
    psgtn_pkg::in_item_t it;
    it.command = cmd; it.reg_addr = a; it.write_data = d;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict(it));
    @(negedge clk);
  endtask

  // Drop valid between bursts for a random gap.
  task automatic maybe_gap();
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      in_item  <= psgtn_pkg::in_item_t'(18'($urandom));
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic wr(input int a, input int d);
    send_item(psgtn_pkg::CMD_WRITE, a[7:0], d[7:0]); maybe_gap();
  endtask
  task automatic rd(input int a);
    send_item(psgtn_pkg::CMD_READ, a[7:0], 8'($urandom)); maybe_gap();
  endtask
  task automatic tk(input int n);
    repeat (n) begin
      send_item(psgtn_pkg::CMD_TICK, 8'($urandom), 8'($urandom)); maybe_gap();
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic test_directed();
    wr(REG_TONE_A_FINE, 8'hFF); wr(REG_TONE_A_COARSE, 8'hFF);
    wr(REG_TONE_B_FINE, 0); wr(REG_TONE_B_COARSE, 0);
    rd(REG_TONE_A_FINE); rd(REG_TONE_A_COARSE); rd(psgtn_pkg::REG_SHAPE);
    rd(200); rd(255);
    wr(99, 8'h5A); rd(99);
    send_item(CMD_UNUSED, 8'h00, 8'hFF);
    wr(psgtn_pkg::REG_NOISE, 0); wr(psgtn_pkg::REG_ENV_FINE, 0);
    wr(psgtn_pkg::REG_ENV_COARSE, 0); wr(psgtn_pkg::REG_VOL0, 8'h1F);
    wr(psgtn_pkg::REG_MIXER, 0);
    wr(psgtn_pkg::REG_SHAPE, 8'h04); tk(6);
    wr(psgtn_pkg::REG_SHAPE, 8'h0E); tk(4);
    // zero tone period
    wr(REG_TONE_A_FINE, 8'h00); wr(REG_TONE_A_COARSE, 0); tk(2);
    // period lowered far below the count
    wr(REG_TONE_A_FINE, 8'h80); tk(40); wr(REG_TONE_A_FINE, 3); tk(2);
    drain();
  endtask

  task automatic test_pressure();
    hold_off = 1;
    repeat (20) tk(1);
    hold_off = 0;
    drain();
  endtask

  task automatic test_random(input int n);
    int a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          a = $urandom_range(0, 15);
          // keep periods short most of the time so the envelope moves
          if (a inside {psgtn_pkg::REG_ENV_FINE, psgtn_pkg::REG_ENV_COARSE} &&
              $urandom_range(0, 3) != 0) wr(a, $urandom_range(0, 3));
          else if (a inside {REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE} &&
                   $urandom_range(0, 1)) wr(a, 0);
          else wr(a, $urandom);
        end
        2: rd($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 15));
        3: if ($urandom_range(0, 9) == 0) wr($urandom_range(16, 255), $urandom);
           else send_item(CMD_UNUSED, 8'($urandom), 8'($urandom));
        default: tk(1);
      endcase
    end
    drain();
  endtask

  // Receiver: stall on its own pattern; long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
        wait (!hold_off);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0) && (cycles % 512 > 128);
      end
    end
  end

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    psgtn_pkg::out_item_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_item.read_data !== exp_r.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time,
                   exp_r.read_data, out_item.read_data);
          errors++;
        end
        if (out_item.dac_index !== exp_r.dac_index) begin
          $display("%0t: dac_index expected %h actual %h", $time,
                   exp_r.dac_index, out_item.dac_index);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_psg_tone_noise_envelope: errors");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    model_reset();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_pressure();
    test_random(1800);
    if (errors == 0) $display("tb_psg_tone_noise_envelope: clean");
    else $display("tb_psg_tone_noise_envelope: errors");
    $finish;
  end

endmodule
